// ===== design/best_fit_buffer_pool_unit_assert.svh =====
// Assertion macros for the buffer pool unit; they sample on clk and are disabled in reset.
`ifndef BEST_FIT_BUFFER_POOL_UNIT_ASSERT_SVH
`define BEST_FIT_BUFFER_POOL_UNIT_ASSERT_SVH

// cond in this cycle implies expr in the same cycle
`define BFBP_ASSERT_NOW(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("bfbp check failed");

// cond in this cycle implies expr in the next cycle
`define BFBP_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("bfbp check failed");

`endif

// ===== design/bfbp_pkg.sv =====
// Shared constants, codes and types of the buffer pool unit.
package bfbp_pkg;

  localparam int SLOTS     = 64;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int SIZE_BITS = 24;
  localparam int BYTES_W   = 30;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_REUSED     = 3'd0,
    ST_NEW        = 3'd1,
    ST_ALLOC_FAIL = 3'd2,
    ST_FREED      = 3'd3,
    ST_FREE_BAD   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [IDX_W-1:0]     entry_index;
    logic [SIZE_BITS-1:0] entry_size;
    logic [BYTES_W-1:0]   pool_bytes;
    logic [CNT_W-1:0]     entries_created;
    logic [CNT_W-1:0]     entries_busy;
    logic [CNT_W-1:0]     entries_idle;
  } res_t;

endpackage

// ===== design/bfbp_chan_if.sv =====
// Request and result channel interfaces of the buffer pool unit.
interface bfbp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [bfbp_pkg::SIZE_BITS-1:0] req_size;
  logic [bfbp_pkg::IDX_W-1:0]     handle;

  modport source (output valid, output operation, output req_size, output handle,
                  input ready);
  modport sink   (input valid, input operation, input req_size, input handle,
                  output ready);
endinterface

interface bfbp_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     status;
  logic [bfbp_pkg::IDX_W-1:0]     entry_index;
  logic [bfbp_pkg::SIZE_BITS-1:0] entry_size;
  logic [bfbp_pkg::BYTES_W-1:0]   pool_bytes;
  logic [bfbp_pkg::CNT_W-1:0]     entries_created;
  logic [bfbp_pkg::CNT_W-1:0]     entries_busy;
  logic [bfbp_pkg::CNT_W-1:0]     entries_idle;

  modport source (output valid, output status, output entry_index, output entry_size,
                  output pool_bytes, output entries_created, output entries_busy,
                  output entries_idle, input ready);
  modport sink   (input valid, input status, input entry_index, input entry_size,
                  input pool_bytes, input entries_created, input entries_busy,
                  input entries_idle, output ready);
endinterface

// ===== design/bfbp_size_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module bfbp_size_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bfbp_ctrl.sv =====
// Sequencer: best-fit scan over the size RAM, busy marks and pool statistics.
module bfbp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  bfbp_in_if.sink         in_ch,
  output logic            res_valid,
  input  logic            res_ready,
  output bfbp_pkg::res_t  res
);

  localparam int IDX_W   = bfbp_pkg::IDX_W;
  localparam int CNT_W   = bfbp_pkg::CNT_W;
  localparam int SIZE_W  = bfbp_pkg::SIZE_BITS;
  localparam int BYTES_W = bfbp_pkg::BYTES_W;

  bfbp_pkg::state_t state_r, state_nxt;
  logic                    op_r, op_nxt;
  logic [SIZE_W-1:0]       req_r, req_nxt;
  logic [IDX_W-1:0]        hdl_r, hdl_nxt;
  logic [CNT_W-1:0]        scan_r, scan_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    found_r, found_nxt;
  logic [SIZE_W-1:0]       best_r, best_nxt;
  logic [IDX_W-1:0]        pick_r, pick_nxt;
  logic [bfbp_pkg::SLOTS-1:0] busy_r, busy_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [BYTES_W-1:0]      bytes_r, bytes_nxt;
  logic [CNT_W-1:0]        nbusy_r, nbusy_nxt;
  logic [CNT_W-1:0]        nidle_r, nidle_nxt;

  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SIZE_W-1:0] ram_rdata;
  logic              cand;

  bfbp_size_ram #(
    .DEPTH (bfbp_pkg::SLOTS),
    .WIDTH (SIZE_W)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (req_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == bfbp_pkg::S_IDLE);

  // free entry that fits and is no larger than the best so far; ties go to the later index
  assign cand = rd_pend_r && !busy_r[rd_idx_r] && (ram_rdata >= req_r) &&
                (!found_r || (ram_rdata <= best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bfbp_pkg::S_IDLE;
      rd_pend_r <= 1'b0;
      busy_r    <= '0;
      count_r   <= '0;
      bytes_r   <= '0;
      nbusy_r   <= '0;
      nidle_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      busy_r    <= busy_nxt;
      count_r   <= count_nxt;
      bytes_r   <= bytes_nxt;
      nbusy_r   <= nbusy_nxt;
      nidle_r   <= nidle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    req_r    <= req_nxt;
    hdl_r    <= hdl_nxt;
    scan_r   <= scan_nxt;
    rd_idx_r <= rd_idx_nxt;
    found_r  <= found_nxt;
    best_r   <= best_nxt;
    pick_r   <= pick_nxt;
  end

  always_comb begin
    logic free_ok;
    state_nxt   = state_r;
    op_nxt      = op_r;
    req_nxt     = req_r;
    hdl_nxt     = hdl_r;
    scan_nxt    = scan_r;
    rd_pend_nxt = rd_pend_r;
    rd_idx_nxt  = rd_idx_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    pick_nxt    = pick_r;
    busy_nxt    = busy_r;
    count_nxt   = count_r;
    bytes_nxt   = bytes_r;
    nbusy_nxt   = nbusy_r;
    nidle_nxt   = nidle_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = scan_r[IDX_W-1:0];
    res_valid   = 1'b0;
    free_ok     = (CNT_W'(hdl_r) < count_r) && busy_r[hdl_r];

    res.status          = bfbp_pkg::ST_ALLOC_FAIL;
    res.entry_index     = '0;
    res.entry_size      = '0;
    res.pool_bytes      = bytes_r;
    res.entries_created = count_r;
    res.entries_busy    = nbusy_r;
    res.entries_idle    = nidle_r;

    case (state_r)
      bfbp_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt      = in_ch.operation;
          req_nxt     = in_ch.req_size;
          hdl_nxt     = in_ch.handle;
          scan_nxt    = '0;
          found_nxt   = 1'b0;
          rd_pend_nxt = 1'b0;
          if (in_ch.operation == bfbp_pkg::OP_FREE) begin
            state_nxt = bfbp_pkg::S_FREE_RD;
          end else if (in_ch.req_size == '0) begin
            state_nxt = bfbp_pkg::S_DONE;
          end else begin
            state_nxt = bfbp_pkg::S_SCAN;
          end
        end
      end

      bfbp_pkg::S_SCAN: begin
        if (cand) begin
          found_nxt = 1'b1;
          best_nxt  = ram_rdata;
          pick_nxt  = rd_idx_r;
        end
        if (scan_r < count_r) begin
          ram_re      = 1'b1;
          scan_nxt    = scan_r + 1'b1;
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = scan_r[IDX_W-1:0];
        end else begin
          rd_pend_nxt = 1'b0;
          if (!rd_pend_r) begin
            state_nxt = bfbp_pkg::S_DONE;
          end
        end
      end

      bfbp_pkg::S_FREE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = hdl_r;
        state_nxt = bfbp_pkg::S_DONE;
      end

      bfbp_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (op_r == bfbp_pkg::OP_FREE) begin
          res.entry_index = hdl_r;
          if (free_ok) begin
            res.status       = bfbp_pkg::ST_FREED;
            res.entry_size   = ram_rdata;
            res.entries_busy = (nbusy_r != '0) ? nbusy_r - 1'b1 : nbusy_r;
            res.entries_idle = nidle_r + 1'b1;
          end else begin
            res.status = bfbp_pkg::ST_FREE_BAD;
          end
        end else if (req_r == '0) begin
          res.status = bfbp_pkg::ST_ALLOC_FAIL;
        end else if (found_r) begin
          res.status       = bfbp_pkg::ST_REUSED;
          res.entry_index  = pick_r;
          res.entry_size   = best_r;
          res.entries_busy = nbusy_r + 1'b1;
          res.entries_idle = (nidle_r != '0) ? nidle_r - 1'b1 : nidle_r;
        end else if (count_r >= CNT_W'(bfbp_pkg::SLOTS)) begin
          res.status = bfbp_pkg::ST_ALLOC_FAIL;
        end else begin
          res.status          = bfbp_pkg::ST_NEW;
          res.entry_index     = count_r[IDX_W-1:0];
          res.entry_size      = req_r;
          res.pool_bytes      = bytes_r + BYTES_W'(req_r);
          res.entries_created = count_r + 1'b1;
          res.entries_busy    = nbusy_r + 1'b1;
        end

        if (res_ready) begin
          state_nxt = bfbp_pkg::S_IDLE;
          bytes_nxt = res.pool_bytes;
          count_nxt = res.entries_created;
          nbusy_nxt = res.entries_busy;
          nidle_nxt = res.entries_idle;
          case (res.status)
            bfbp_pkg::ST_REUSED: busy_nxt[pick_r] = 1'b1;
            bfbp_pkg::ST_NEW: begin
              busy_nxt[count_r[IDX_W-1:0]] = 1'b1;
              ram_we = 1'b1;
            end
            bfbp_pkg::ST_FREED: busy_nxt[hdl_r] = 1'b0;
            default: ;
          endcase
        end
      end

      default: state_nxt = bfbp_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== design/best_fit_buffer_pool_unit.sv =====
// Top level of the best-fit buffer pool: sequencer plus result output register.
// Allocate: the scan reads each created entry once through the size RAM read port.
// Free reads the size of its handle, a zero-size allocate skips the scan; one item is
// in work at a time.
// Reset clears busy marks, counters and the output valid; sizes stay unknown
// until written, and are only used for created entries.
module best_fit_buffer_pool_unit (
  input  logic       clk,
  input  logic       rst_n,
  bfbp_in_if.sink    in_ch,
  bfbp_out_if.source out_ch
);

  `include "best_fit_buffer_pool_unit_assert.svh"

  localparam int CNT_W = bfbp_pkg::CNT_W;

  logic           res_valid;
  logic           res_ready;
  bfbp_pkg::res_t res;
  bfbp_pkg::res_t out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic           cnt_ok;
  logic           created_ok;
  logic           out_fail;
  logic           out_empty;

  bfbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_r.status;
  assign out_ch.entry_index     = out_r.entry_index;
  assign out_ch.entry_size      = out_r.entry_size;
  assign out_ch.pool_bytes      = out_r.pool_bytes;
  assign out_ch.entries_created = out_r.entries_created;
  assign out_ch.entries_busy    = out_r.entries_busy;
  assign out_ch.entries_idle    = out_r.entries_idle;

  assign cnt_ok     = ({1'b0, out_r.entries_busy} + {1'b0, out_r.entries_idle}) ==
                      {1'b0, out_r.entries_created};
  assign created_ok = out_r.entries_created <= CNT_W'(bfbp_pkg::SLOTS);
  assign out_fail   = out_valid_r && (out_r.status == bfbp_pkg::ST_ALLOC_FAIL);
  assign out_empty  = (out_r.entry_index == '0) && (out_r.entry_size == '0);

  `BFBP_ASSERT_NOW(a_count_balance, out_valid_r, cnt_ok)
  `BFBP_ASSERT_NOW(a_created_max, out_valid_r, created_ok)
  `BFBP_ASSERT_NOW(a_fail_empty, out_fail, out_empty)
  `BFBP_ASSERT_NEXT(a_one_in_work, (in_ch.valid && in_ch.ready), !in_ch.ready)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for best_fit_buffer_pool_unit: random request bursts, pool predictor.
module tb;
  import bfbp_pkg::*;

  localparam int RANDOM_REQS = 1000;
  localparam int REPORT_MAX  = 40;

  typedef struct packed {
    logic                 hold;   // wait until every result is back before sending
    logic                 live;   // free: pick a busy entry at send time
    op_t                  op;
    logic [SIZE_BITS-1:0] size;
    logic [IDX_W-1:0]     handle;
  } pool_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  bfbp_in_if  in_ch ();
  bfbp_out_if out_ch ();

  best_fit_buffer_pool_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // request side drive
  logic                 drv_valid  = 1'b0;
  op_t                  drv_op     = OP_ALLOC;
  logic [SIZE_BITS-1:0] drv_size   = '0;
  logic [IDX_W-1:0]     drv_handle = '0;
  logic                 rx_ready   = 1'b0;

  assign in_ch.valid     = drv_valid;
  assign in_ch.operation = drv_op;
  assign in_ch.req_size  = drv_size;
  assign in_ch.handle    = drv_handle;
  assign out_ch.ready    = rx_ready;

  // predicted pool state
  logic [SIZE_BITS-1:0] slot_bytes [SLOTS];
  logic                 busy_mark  [SLOTS];
  logic [CNT_W-1:0]     created_cnt;
  logic [CNT_W-1:0]     busy_cnt;
  logic [CNT_W-1:0]     idle_cnt;
  logic [BYTES_W-1:0]   total_bytes;

  pool_req_t pending_reqs [$];
  res_t      pool_results_due [$];

  int items_in    = 0;
  int results_out = 0;
  int mismatches  = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch on %s at result %0d: got %0d, expected %0d", what, results_out, got,
               want);
  endtask

  // Apply one accepted request to the predicted pool and queue the result it gives.
  task automatic apply_pool_request(input op_t op, input logic [SIZE_BITS-1:0] size,
                                    input logic [IDX_W-1:0] h);
    res_t             r;
    logic             hit;
    logic [IDX_W-1:0] pick;
    r = '0;
    hit = 1'b0;
    pick = '0;
    if (op == OP_ALLOC) begin
      r.status = ST_ALLOC_FAIL;
      if (size != '0) begin
        // <= keeps the newest entry among equal sizes
        for (int i = 0; i < SLOTS; i++) begin
          if (i < created_cnt && !busy_mark[i] && slot_bytes[i] >= size &&
              (!hit || slot_bytes[i] <= slot_bytes[pick])) begin
            pick = IDX_W'(i);
            hit = 1'b1;
          end
        end
        if (hit) begin
          busy_mark[pick] = 1'b1;
          busy_cnt++;
          if (idle_cnt != '0) idle_cnt--;
          r.status = ST_REUSED;
          r.entry_index = pick;
          r.entry_size = slot_bytes[pick];
        end else if (created_cnt < SLOTS) begin
          pick = created_cnt[IDX_W-1:0];
          slot_bytes[pick] = size;
          busy_mark[pick] = 1'b1;
          created_cnt++;
          busy_cnt++;
          total_bytes = total_bytes + BYTES_W'(size);
          r.status = ST_NEW;
          r.entry_index = pick;
          r.entry_size = size;
        end
      end
    end else if (h < created_cnt && busy_mark[h]) begin
      busy_mark[h] = 1'b0;
      if (busy_cnt != '0) busy_cnt--;
      idle_cnt++;
      r.status = ST_FREED;
      r.entry_index = h;
      r.entry_size = slot_bytes[h];
    end else begin
      r.status = ST_FREE_BAD;
      r.entry_index = h;
    end
    r.pool_bytes = total_bytes;
    r.entries_created = created_cnt;
    r.entries_busy = busy_cnt;
    r.entries_idle = idle_cnt;
    pool_results_due.push_back(r);
  endtask

  task automatic queue_req(input logic hold, input logic live, input op_t op,
                           input logic [SIZE_BITS-1:0] size, input logic [IDX_W-1:0] handle);
    pool_req_t q;
    q.hold = hold;
    q.live = live;
    q.op = op;
    q.size = size;
    q.handle = handle;
    pending_reqs.push_back(q);
  endtask

  // Driver: bursts of items separated by random gaps.
  int                gap_left   = 0;
  int                burst_left = 0;
  int                n_busy;
  int                k;
  pool_req_t         nxt;
  logic [IDX_W-1:0]  h_pick;

  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        apply_pool_request(drv_op, drv_size, drv_handle);
        items_in <= items_in + 1;
      end
      if (!drv_valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          drv_valid <= 1'b0;
        end else if (pending_reqs[0].hold && (drv_valid || items_in != results_out)) begin
          drv_valid <= 1'b0;
        end else begin
          nxt = pending_reqs.pop_front();
          h_pick = nxt.handle;
          if (nxt.live) begin
            n_busy = 0;
            for (int i = 0; i < SLOTS; i++)
              if (busy_mark[i]) n_busy++;
            if (n_busy > 0) begin
              k = $urandom_range(n_busy - 1);
              for (int i = 0; i < SLOTS; i++) begin
                if (busy_mark[i]) begin
                  if (k == 0) h_pick = IDX_W'(i);
                  k--;
                end
              end
            end
          end
          drv_valid  <= 1'b1;
          drv_op     <= nxt.op;
          drv_size   <= nxt.size;
          drv_handle <= h_pick;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Monitor and result-side stall pattern.
  res_t     want;
  int       rx_mode = 0;
  int       rx_left = 0;
  bit [2:0] rx_tick = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rx_ready) begin
        results_out <= results_out + 1;
        if (pool_results_due.size() == 0) begin
          report_mismatch("result with nothing due", out_ch.status, 0);
        end else begin
          want = pool_results_due.pop_front();
          if (out_ch.status != want.status)
            report_mismatch("status", out_ch.status, want.status);
          if (out_ch.entry_index != want.entry_index)
            report_mismatch("entry_index", out_ch.entry_index, want.entry_index);
          if (out_ch.entry_size != want.entry_size)
            report_mismatch("entry_size", out_ch.entry_size, want.entry_size);
          if (out_ch.pool_bytes != want.pool_bytes)
            report_mismatch("pool_bytes", out_ch.pool_bytes, want.pool_bytes);
          if (out_ch.entries_created != want.entries_created)
            report_mismatch("entries_created", out_ch.entries_created, want.entries_created);
          if (out_ch.entries_busy != want.entries_busy)
            report_mismatch("entries_busy", out_ch.entries_busy, want.entries_busy);
          if (out_ch.entries_idle != want.entries_idle)
            report_mismatch("entries_idle", out_ch.entries_idle, want.entries_idle);
        end
      end
      // modes: always ready, coin flip, one cycle in eight
      if (rx_left == 0) begin
        rx_mode = $urandom_range(2);
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        0: rx_ready <= 1'b1;
        1: rx_ready <= 1'($urandom_range(1));
        default: rx_ready <= (rx_tick == 3'd0);
      endcase
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int                   alloc_pct;
    logic [SIZE_BITS-1:0] sz;
    for (int i = 0; i < SLOTS; i++) begin
      slot_bytes[i] = '0;
      busy_mark[i] = 1'b0;
    end
    created_cnt = '0;
    busy_cnt = '0;
    idle_cnt = '0;
    total_bytes = '0;

    // directed: empty table, zero size, ties, double free, absent entries
    queue_req(1'b0, 1'b0, OP_FREE,  24'd0,        6'd0);
    queue_req(1'b0, 1'b0, OP_ALLOC, 24'd0,        6'd63);
    queue_req(1'b0, 1'b0, OP_ALLOC, 24'hFFFFFF,   6'd0);
    queue_req(1'b0, 1'b0, OP_ALLOC, 24'd1,        6'd0);
    queue_req(1'b0, 1'b0, OP_ALLOC, 24'd5,        6'd0);
    queue_req(1'b0, 1'b0, OP_ALLOC, 24'd5,        6'd0);
    queue_req(1'b0, 1'b0, OP_FREE,  24'hFFFFFF,   6'd2);
    queue_req(1'b0, 1'b0, OP_FREE,  24'd0,        6'd3);
    queue_req(1'b0, 1'b0, OP_ALLOC, 24'd3,        6'd0);
    queue_req(1'b0, 1'b0, OP_FREE,  24'd0,        6'd3);
    queue_req(1'b0, 1'b0, OP_FREE,  24'd0,        6'd3);
    queue_req(1'b0, 1'b0, OP_FREE,  24'd0,        6'd63);
    queue_req(1'b0, 1'b0, OP_FREE,  24'd0,        6'd4);
    queue_req(1'b0, 1'b0, OP_ALLOC, 24'd4,        6'd0);
    queue_req(1'b0, 1'b0, OP_ALLOC, 24'd5,        6'd0);
    queue_req(1'b0, 1'b0, OP_FREE,  24'd0,        6'd0);
    queue_req(1'b0, 1'b0, OP_ALLOC, 24'h800000,   6'd0);
    queue_req(1'b0, 1'b0, OP_FREE,  24'd0,        6'd1);
    queue_req(1'b0, 1'b0, OP_ALLOC, 24'd2,        6'd0);
    queue_req(1'b0, 1'b0, OP_ALLOC, 24'd1,        6'd0);
    queue_req(1'b0, 1'b0, OP_FREE,  24'd0,        6'd0);

    // random: allocation-heavy start fills the table, then a mix with reuse and misses
    for (int n = 0; n < RANDOM_REQS; n++) begin
      alloc_pct = (n < 150) ? 85 : 55;
      if ($urandom_range(99) < alloc_pct) begin
        case ($urandom_range(19))
          0:       sz = '0;
          1:       sz = 24'hFFFFFF;
          2, 3, 4: sz = SIZE_BITS'($urandom);
          5:       sz = SIZE_BITS'($urandom_range(1, 8)) << 20;
          default: sz = SIZE_BITS'($urandom_range(1, 64));
        endcase
        queue_req(n % 250 == 0, 1'b0, OP_ALLOC, sz, IDX_W'($urandom_range(63)));
      end else begin
        queue_req(n % 250 == 0, $urandom_range(9) < 8, OP_FREE, SIZE_BITS'($urandom),
                  IDX_W'($urandom_range(63)));
      end
    end

    while (pending_reqs.size() != 0 || drv_valid) @(posedge clk);
    while (items_in != results_out) @(posedge clk);
    repeat (100) @(posedge clk);
    if (pool_results_due.size() != 0)
      report_mismatch("results never delivered", pool_results_due.size(), 0);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== best_fit_buffer_pool_unit.f =====
+incdir+design
design/bfbp_pkg.sv
design/bfbp_chan_if.sv
design/bfbp_size_ram.sv
design/bfbp_ctrl.sv
design/best_fit_buffer_pool_unit.sv
tb/tb.sv
